FILE: rtl/paged_mono_sprite_blitter_assert.svh
// Assertion macros for the paged monochrome sprite blitter checkers.
`ifndef PAGED_MONO_SPRITE_BLITTER_ASSERT_SVH
`define PAGED_MONO_SPRITE_BLITTER_ASSERT_SVH

// Clocked assertion, off while reset is held.
`define PMSB_ASSERT(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) else $error(msg);

// Clocked assertion, also checked while reset is held.
`define PMSB_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) (prop)) else $error(msg);

`endif

FILE: rtl/pmsb_pkg.sv
// Shared types and constants of the paged monochrome sprite blitter.
package pmsb_pkg;

    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 64;

    localparam int DX_W        = 10;
    localparam int PAGE_W      = 6;
    localparam int IDX_W       = 10;
    localparam int MODE_W      = 6;
    localparam int QUEUE_DEPTH = 4;

    localparam int S_TDATA_W     = 80;
    localparam int M_TDATA_W     = 24;
    localparam int RES_PAYLOAD_W = IDX_W + 8;

    localparam int MODE_BIT_WHITEBLACK   = 0;
    localparam int MODE_BIT_INVERT       = 1;
    localparam int MODE_BIT_BLACK        = 2;
    localparam int MODE_BIT_REVERSEBLACK = 3;
    localparam int MODE_BIT_MASKED       = 4;
    localparam int MODE_BIT_FLIP         = 5;

    typedef struct packed {
        logic [15:0]       pix;
        logic [15:0]       msk;
        logic              inv;
        logic              up_ok;
        logic              lo_ok;
        logic [PAGE_W-1:0] up_page;
        logic [PAGE_W-1:0] lo_page;
        logic [DX_W-1:0]   dx;
    } item_t;

    typedef struct packed {
        logic             last;
        logic [7:0]       value;
        logic [IDX_W-1:0] idx;
    } res_t;

endpackage

FILE: rtl/pmsb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pmsb_ram
    import pmsb_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/pmsb_queue.sv
// Small register FIFO with an occupancy count.
module pmsb_queue
    import pmsb_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           pop_data,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = slot_reg[rd_ptr_reg];
    assign count    = count_reg;

endmodule

FILE: rtl/pmsb_front.sv
// Front end: accept a column byte beat, clip it and work out page writes.
module pmsb_front
    import pmsb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
)
(
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [S_TDATA_W-1:0]             s_axis_tdata,
    input  logic [MODE_W-1:0]                s_axis_tuser,
    input  logic                             clearing,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count,
    output logic                             push,
    output item_t                            push_data
);

    localparam int PAGE_COUNT = SCREEN_HEIGHT / 8;
    localparam logic signed [17:0] SW_S  = 18'(SCREEN_WIDTH);
    localparam logic signed [17:0] SH_S  = 18'(SCREEN_HEIGHT);
    localparam logic signed [14:0] PC_S  = 15'(PAGE_COUNT);
    localparam logic signed [14:0] PCM_S = 15'(PAGE_COUNT - 1);

    logic signed [17:0] xs, ys, x_end, y_end, py, dx;
    logic signed [14:0] dpage;
    logic [7:0]         w, h, col, img, mb, vm, im, mk;
    logic [4:0]         page;
    logic [5:0]         pages;
    logic [8:0]         h_round;
    logic [2:0]         shift;
    logic [MODE_W-1:0]  mode;
    logic               off_screen, outside, col_ok, up_ok, lo_ok, keep;

    always_comb
    begin
        xs    = {{2{s_axis_tdata[15]}}, s_axis_tdata[15:0]};
        ys    = {{2{s_axis_tdata[31]}}, s_axis_tdata[31:16]};
        w     = s_axis_tdata[39:32];
        h     = s_axis_tdata[47:40];
        col   = s_axis_tdata[55:48];
        page  = s_axis_tdata[60:56];
        img   = s_axis_tdata[68:61];
        mb    = s_axis_tdata[76:69];
        mode  = s_axis_tuser;

        x_end = xs + {10'b0, w};
        y_end = ys + {10'b0, h};
        off_screen = (w == 8'd0) || (h == 8'd0) || (x_end <= 18'sd0) || (y_end <= 18'sd0)
                     || (xs >= SW_S) || (ys >= SH_S);

        h_round = {1'b0, h} + 9'd7;
        pages   = h_round[8:3];
        outside = (col >= w) || ({1'b0, page} >= pages);

        vm = 8'hFF;
        if (({1'b0, page} + 6'd1 == pages) && (h[2:0] != 3'd0))
        begin
            vm = 8'((9'd1 << h[2:0]) - 9'd1);
        end

        py    = ys + {10'b0, page, 3'b0};
        shift = py[2:0];
        dpage = py[17:3];

        if (mode[MODE_BIT_FLIP])
        begin
            dx = x_end - 18'sd1 - {10'b0, col};
        end
        else
        begin
            dx = xs + {10'b0, col};
        end
        col_ok = (dx >= 18'sd0) && (dx < SW_S);

        up_ok = (dpage >= 15'sd0) && (dpage < PC_S);
        lo_ok = (shift != 3'd0) && (dpage >= -15'sd1) && (dpage < PCM_S);

        im = img & vm;
        if (mode[MODE_BIT_REVERSEBLACK])
        begin
            im = im ^ vm;
        end
        mk = mode[MODE_BIT_MASKED] ? (mb & vm) : vm;
        if (mode[MODE_BIT_WHITEBLACK])
        begin
            mk = im;
        end
        if (mode[MODE_BIT_BLACK])
        begin
            im = 8'd0;
        end

        keep = !off_screen && !outside && col_ok && (up_ok || lo_ok);

        push_data.pix     = {8'd0, im} << shift;
        push_data.msk     = {8'd0, mk} << shift;
        push_data.inv     = mode[MODE_BIT_INVERT];
        push_data.up_ok   = up_ok;
        push_data.lo_ok   = lo_ok;
        push_data.up_page = dpage[PAGE_W-1:0];
        push_data.lo_page = PAGE_W'(dpage + 15'sd1);
        push_data.dx      = dx[DX_W-1:0];
    end

    assign s_axis_tready = !clearing && (q_count < ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready && keep;

endmodule

FILE: rtl/pmsb_back.sv
// Back end: framebuffer read-modify-write per page, clearing pass after reset.
module pmsb_back
    import pmsb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             item_valid,
    input  item_t                            item_data,
    output logic                             item_pop,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0] res_count,
    output logic                             res_push,
    output res_t                             res_data,
    output logic                             clearing
);

    localparam int PAGE_COUNT = SCREEN_HEIGHT / 8;
    localparam int DEPTH      = PAGE_COUNT * SCREEN_WIDTH;
    localparam int AW         = $clog2(DEPTH);
    localparam int CW         = $clog2(QUEUE_DEPTH + 1) + 1;

    item_t         cur_reg, cur_next;
    logic          up_pend_reg, up_pend_next;
    logic          lo_pend_reg, lo_pend_next;
    logic          s2_valid_reg, s2_valid_next;
    logic [AW-1:0] s2_idx_reg, s2_idx_next;
    logic [7:0]    s2_pix_reg, s2_pix_next;
    logic [7:0]    s2_msk_reg, s2_msk_next;
    logic          s2_inv_reg, s2_inv_next;
    logic          s2_last_reg, s2_last_next;
    logic          fw_valid_reg, fw_valid_next;
    logic [AW-1:0] fw_idx_reg, fw_idx_next;
    logic [7:0]    fw_val_reg, fw_val_next;
    logic          clr_active_reg, clr_active_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    logic              can_issue, issue_up, issue_lo, issue;
    logic [PAGE_W-1:0] op_page;
    logic [AW-1:0]     op_idx;
    logic [7:0]        cur_val, new_val, ram_rdata, ram_wdata;
    logic [AW-1:0]     ram_waddr;
    logic              ram_we;
    logic [AW+IDX_W-1:0] idx_ext;

    always_comb
    begin
        can_issue = !clr_active_reg
                    && ((CW'(res_count) + CW'(s2_valid_reg)) < CW'(QUEUE_DEPTH));
        issue_up  = can_issue && up_pend_reg;
        issue_lo  = can_issue && !up_pend_reg && lo_pend_reg;
        issue     = issue_up || issue_lo;
        op_page   = issue_up ? cur_reg.up_page : cur_reg.lo_page;
        op_idx    = AW'(32'(op_page) * 32'(SCREEN_WIDTH) + 32'(cur_reg.dx));

        up_pend_next = up_pend_reg && !issue_up;
        lo_pend_next = lo_pend_reg && !issue_lo;
        cur_next     = cur_reg;
        item_pop     = item_valid && !clr_active_reg && !up_pend_next && !lo_pend_next;
        if (item_pop)
        begin
            cur_next     = item_data;
            up_pend_next = item_data.up_ok;
            lo_pend_next = item_data.lo_ok;
        end

        s2_valid_next = issue;
        s2_idx_next   = op_idx;
        s2_pix_next   = issue_up ? cur_reg.pix[7:0] : cur_reg.pix[15:8];
        s2_msk_next   = issue_up ? cur_reg.msk[7:0] : cur_reg.msk[15:8];
        s2_inv_next   = cur_reg.inv;
        s2_last_next  = issue_lo || !lo_pend_reg;

        cur_val = (fw_valid_reg && (fw_idx_reg == s2_idx_reg)) ? fw_val_reg : ram_rdata;
        if (s2_inv_reg)
        begin
            new_val = cur_val ^ (s2_pix_reg & s2_msk_reg);
        end
        else
        begin
            new_val = (cur_val & ~s2_msk_reg) | (s2_pix_reg & s2_msk_reg);
        end

        fw_valid_next = fw_valid_reg || s2_valid_reg;
        fw_idx_next   = s2_valid_reg ? s2_idx_reg : fw_idx_reg;
        fw_val_next   = s2_valid_reg ? new_val : fw_val_reg;

        clr_addr_next   = clr_addr_reg + 1'b1;
        clr_active_next = clr_active_reg && (clr_addr_reg != AW'(DEPTH - 1));

        ram_we    = clr_active_reg || s2_valid_reg;
        ram_waddr = clr_active_reg ? clr_addr_reg : s2_idx_reg;
        ram_wdata = clr_active_reg ? 8'd0 : new_val;

        idx_ext        = {{IDX_W{1'b0}}, s2_idx_reg};
        res_push       = s2_valid_reg;
        res_data.idx   = idx_ext[IDX_W-1:0];
        res_data.value = new_val;
        res_data.last  = s2_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_pend_reg    <= 1'b0;
            lo_pend_reg    <= 1'b0;
            s2_valid_reg   <= 1'b0;
            fw_valid_reg   <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            up_pend_reg    <= up_pend_next;
            lo_pend_reg    <= lo_pend_next;
            s2_valid_reg   <= s2_valid_next;
            fw_valid_reg   <= fw_valid_next;
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        s2_idx_reg  <= s2_idx_next;
        s2_pix_reg  <= s2_pix_next;
        s2_msk_reg  <= s2_msk_next;
        s2_inv_reg  <= s2_inv_next;
        s2_last_reg <= s2_last_next;
        fw_idx_reg  <= fw_idx_next;
        fw_val_reg  <= fw_val_next;
    end

    pmsb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (op_idx),
        .rdata (ram_rdata)
    );

    assign clearing = clr_active_reg;

endmodule

FILE: rtl/paged_mono_sprite_blitter.sv
// Top level of the paged monochrome sprite blitter.
//
//  channel   dir  beat                                 fields
//  s_axis    in   one sprite column byte               tdata: position, size, column,
//                                                      page, image, mask; tuser: mode
//  m_axis    out  one framebuffer byte written         tdata: index, value; tlast: last
//
// Each item writes at most 2 destination pages: each page is one read-modify-write on the
// single write port of the framebuffer RAM.
// After reset the framebuffer, (SCREEN_HEIGHT / 8) * SCREEN_WIDTH bytes (1024 by default),
// is cleared one byte per cycle with s_axis_tready low.
// A 4-entry item queue and a 4-entry result queue absorb stalls on either side.
module paged_mono_sprite_blitter
    import pmsb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // sprite_x, sprite_y, sprite_width, sprite_height, source_column, source_page,
    // image_bits, mask_bits, zero pad
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // mode
    input  logic [MODE_W-1:0]    s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // write_index, write_value, zero pad
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // last_write
    output logic                 m_axis_tlast
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic                     front_push, item_pop, res_push, res_pop, clearing;
    item_t                    front_item, q_item;
    res_t                     back_res, out_res;
    logic [$bits(item_t)-1:0] q_item_bits;
    logic [$bits(res_t)-1:0]  out_res_bits;
    logic [CW-1:0]            item_count, res_count;

    pmsb_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .clearing      (clearing),
        .q_count       (item_count),
        .push          (front_push),
        .push_data     (front_item)
    );

    pmsb_queue #(
        .WIDTH ($bits(item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_item_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_data (front_item),
        .pop       (item_pop),
        .pop_data  (q_item_bits),
        .count     (item_count)
    );

    assign q_item = q_item_bits;

    pmsb_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_count != '0),
        .item_data  (q_item),
        .item_pop   (item_pop),
        .res_count  (res_count),
        .res_push   (res_push),
        .res_data   (back_res),
        .clearing   (clearing)
    );

    pmsb_queue #(
        .WIDTH ($bits(res_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (back_res),
        .pop       (res_pop),
        .pop_data  (out_res_bits),
        .count     (res_count)
    );

    assign out_res       = out_res_bits;
    assign m_axis_tvalid = (res_count != '0);
    assign res_pop       = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = {{(M_TDATA_W - RES_PAYLOAD_W){1'b0}}, out_res.value, out_res.idx};
    assign m_axis_tlast  = out_res.last;

endmodule

FILE: rtl/pmsb_checker.sv
// Port-level checker of the paged monochrome sprite blitter, bound to the top level.
`include "paged_mono_sprite_blitter_assert.svh"

module pmsb_checker
    import pmsb_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tlast
);

    `PMSB_ASSERT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output beat changed while stalled")
    `PMSB_ASSERT(a_out_pad_zero, clk, rst_n, m_axis_tvalid |-> m_axis_tdata[M_TDATA_W-1:RES_PAYLOAD_W] == '0, "output padding not zero")
    `PMSB_ASSERT_ALWAYS(a_quiet_in_reset, clk, !rst_n |=> !s_axis_tready && !m_axis_tvalid, "handshake active during reset")
    `PMSB_ASSERT_ALWAYS(a_clear_after_reset, clk, $rose(rst_n) |=> !s_axis_tready && !m_axis_tvalid, "input taken during framebuffer clear")

endmodule

bind paged_mono_sprite_blitter pmsb_checker u_pmsb_checker (.*);
